// File: rtl/core/signed_window_scalar_recoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed window scalar recoder.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SIGNED_WINDOW_SCALAR_RECODER_ASSERT_SVH
`define SIGNED_WINDOW_SCALAR_RECODER_ASSERT_SVH

// consequent checked in the same cycle
`define SWSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SWSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// Types and constants shared by the signed window scalar recoder.
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int MAX_BITS_DEF = 256;
  localparam int CFG_W        = 9;
  localparam logic [CFG_W-1:0] SCALAR_BITS_RST = 9'd256;

  // x / 5 == (x * DIV5_MUL) >> DIV5_SHIFT, exact for x well past 1024
  localparam int DIV5_MUL_W = 14;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 14'd13108;
  localparam int DIV5_SHIFT = 16;

  localparam int WIN_BITS = 6;  // five window bits plus the borrow bit below

  typedef struct packed {
    logic [7:0] scalar_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic       digit_sign;
    logic [4:0] digit_magnitude;
    logic       last_digit;
  } out_word_t;

  // queue word: byte plus the front's verdict on it
  typedef struct packed {
    logic [7:0] scalar_byte;
    logic       store;
    logic       last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

// File: rtl/core/swsr_queue.sv
// ----------------------------------------------------------------------------
// swsr_queue
// Two-word queue between the byte front end and the recoding back end.
// ----------------------------------------------------------------------------
module swsr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  swsr_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output swsr_pkg::q_entry_t  head,
  output swsr_pkg::q_status_t status
);

  swsr_pkg::q_entry_t ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head             = ent_r[rp_r];
  assign status.full      = cnt_r[1];
  assign status.not_empty = (cnt_r != 2'd0);

endmodule

// File: rtl/core/swsr_front.sv
// ----------------------------------------------------------------------------
// swsr_front
// Takes scalar bytes, decides whether each fits the store, and queues them.
// ----------------------------------------------------------------------------
module swsr_front #(
  parameter int MAX_BITS = swsr_pkg::MAX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  swsr_pkg::in_word_t  in_data,
  input  swsr_pkg::q_status_t q_stat,
  output logic                busy,
  output logic                push,
  output swsr_pkg::q_entry_t  push_entry
);

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             room;

  assign busy = q_stat.full;
  assign push = start && !busy;
  assign room = (count_r < CNT_W'(STORE_BYTES));

  assign push_entry.scalar_byte = in_data.scalar_byte;
  assign push_entry.store       = room;
  assign push_entry.last        = in_data.last_byte;

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      if (in_data.last_byte) begin
        count_nxt = '0;
      end else if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/swsr_back.sv
// ----------------------------------------------------------------------------
// swsr_back
// Byte store, window sequencer and Booth recoder. One digit per cycle,
// most significant window first, through a read stage and a recode stage.
// ----------------------------------------------------------------------------
`include "signed_window_scalar_recoder_assert.svh"

module swsr_back #(
  parameter int MAX_BITS = swsr_pkg::MAX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swsr_pkg::CFG_W-1:0]   cfg_wdata,
  input  swsr_pkg::q_entry_t           head,
  input  swsr_pkg::q_status_t          q_stat,
  output logic                         pop,
  output logic                         out_valid,
  output swsr_pkg::out_word_t          out_data
);

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int AW_RAW      = $clog2(STORE_BYTES);
  localparam int AW          = (AW_RAW < 1) ? 1 : AW_RAW;
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);
  localparam int LEN_W       = $clog2(MAX_BITS + 1);
  localparam int LW          = (LEN_W > swsr_pkg::CFG_W) ? LEN_W : swsr_pkg::CFG_W;
  localparam int PW          = LW + 1;
  localparam int WIN_RAW     = $clog2((MAX_BITS - 1) / 5 + 1);
  localparam int WIN_W       = (WIN_RAW < 1) ? 1 : WIN_RAW;
  localparam int PROD_W      = LW + swsr_pkg::DIV5_MUL_W;
  localparam int NB          = swsr_pkg::WIN_BITS;

  function automatic swsr_pkg::out_word_t booth(input logic [NB-1:0] b, input logic lst);
    swsr_pkg::out_word_t r;
    logic [NB-1:0] v;
    v                 = b[NB-1] ? ~b : b;
    r.digit_sign      = b[NB-1];
    r.digit_magnitude = 5'({1'b0, v[4:1]}) + 5'(v[0]);
    r.last_digit      = lst;
    return r;
  endfunction

  // configuration
  logic [swsr_pkg::CFG_W-1:0] scalar_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scalar_bits_r <= swsr_pkg::SCALAR_BITS_RST;
    end else if (cfg_we) begin
      scalar_bits_r <= cfg_wdata;
    end
  end

  logic [LW-1:0]     len;
  logic [LW-1:0]     cfg_ext;
  logic [PROD_W-1:0] prod;
  logic [WIN_W-1:0]  top;

  assign cfg_ext = LW'(scalar_bits_r);
  assign len     = (cfg_ext > LW'(MAX_BITS)) ? LW'(MAX_BITS) : cfg_ext;
  assign prod    = PROD_W'(len - LW'(1)) * PROD_W'(swsr_pkg::DIV5_MUL);
  assign top     = prod[swsr_pkg::DIV5_SHIFT +: WIN_W];

  // sequencer
  swsr_pkg::back_state_t state_r, state_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             issue;
  logic             wr_en;

  assign pop   = (state_r == swsr_pkg::BK_IDLE) && q_stat.not_empty;
  assign wr_en = pop && head.store;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swsr_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    issue     = 1'b0;
    case (state_r)
      swsr_pkg::BK_IDLE: begin
        if (pop) begin
          if (head.store) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (head.last) begin
            if (len == '0) begin
              fill_nxt = '0;
            end else begin
              win_nxt   = top;
              state_nxt = swsr_pkg::BK_EMIT;
            end
          end
        end
      end
      swsr_pkg::BK_EMIT: begin
        issue = 1'b1;
        if (win_r == '0) begin
          fill_nxt  = '0;
          state_nxt = swsr_pkg::BK_IDLE;
        end else begin
          win_nxt = win_r - WIN_W'(1);
        end
      end
      default: begin
        state_nxt = swsr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      win_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      win_r  <= win_nxt;
    end
  end

  // window addressing: bits pos-1 .. pos+4 span at most two bytes
  logic [PW-1:0]   pos;
  logic [PW-1:0]   lo;
  logic [PW-1:0]   ix0;
  logic [PW-1:0]   ix1;
  logic            lo_ok;
  logic            hi_ok;
  logic [NB-1:0]   keep;

  assign pos   = PW'({win_r, 2'b00}) + PW'(win_r);
  assign lo    = pos - PW'(1);  // wraps to all ones for window 0: offset 7
  assign ix0   = lo >> 3;
  assign ix1   = (pos + PW'(4)) >> 3;
  assign lo_ok = (win_r != '0) && (ix0 < PW'(fill_r));
  assign hi_ok = (ix1 < PW'(fill_r));

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      keep[i] = ((PW + 1)'(pos) + (PW + 1)'(i)) < ((PW + 1)'(len) + (PW + 1)'(1));
    end
    if (win_r == '0) begin
      keep[0] = 1'b0;
    end
  end

  // store
  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd0_r;
  logic [7:0] rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= head.scalar_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem[ix0[AW-1:0]];
    rd1_r <= mem[ix1[AW-1:0]];
  end

  // read stage
  logic          s1_valid_r;
  logic [2:0]    s1_off_r;
  logic          s1_lo_ok_r;
  logic          s1_hi_ok_r;
  logic [NB-1:0] s1_keep_r;
  logic          s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_off_r   <= lo[2:0];
    s1_lo_ok_r <= lo_ok;
    s1_hi_ok_r <= hi_ok;
    s1_keep_r  <= keep;
    s1_last_r  <= (win_r == '0);
  end

  // recode stage
  logic [15:0]         pair;
  logic [15:0]         shifted;
  logic [NB-1:0]       bits;
  logic                out_valid_r;
  swsr_pkg::out_word_t out_data_r;

  // unloaded or out-of-range bytes read as zero
  assign pair    = {s1_hi_ok_r ? rd1_r : 8'h00, s1_lo_ok_r ? rd0_r : 8'h00};
  assign shifted = pair >> s1_off_r;
  assign bits    = shifted[NB-1:0] & s1_keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= booth(bits, s1_last_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SWSR_ASSERT_SAME(a_fill_range, 1'b1, fill_r <= CNT_W'(STORE_BYTES), "fill count past store size")
  `SWSR_ASSERT_NEXT(a_emit_end, (state_r == swsr_pkg::BK_EMIT) && (win_r == '0), (state_r == swsr_pkg::BK_IDLE) && (fill_r == '0), "store not released after last window")
  `SWSR_ASSERT_NEXT(a_pipe_flow, s1_valid_r, out_valid_r, "read stage digit lost")
  `SWSR_ASSERT_SAME(a_mag_range, out_valid_r, out_data_r.digit_magnitude <= 5'd16, "digit magnitude above 16")
  `SWSR_ASSERT_NEXT(a_gap_after_last, out_valid_r && out_data_r.last_digit, !out_valid_r, "digit right after last digit")

endmodule

// File: rtl/core/signed_window_scalar_recoder.sv
// ----------------------------------------------------------------------------
// signed_window_scalar_recoder
// Loads a scalar byte-wise and emits Booth-recoded signed 5-bit window digits.
// ----------------------------------------------------------------------------
// Bytes enter least significant first with start, one per cycle while busy is
// low; busy rises when the two-word queue in front of the store is full, which
// happens while a scalar's digits are being produced. The byte marked last
// starts emission: ceil(len/5) digits, len = min(scalar_bits, MAX_BITS), most
// significant window first, one per cycle on out_valid, the first appearing
// after the last byte leaves the queue, through the emit state, the read
// stage and the recode stage. A digit is shown for a single cycle and cannot
// be stalled. A single-write, two-read byte store feeds the one-digit-
// per-cycle recoder. Write scalar_bits only while no scalar is in flight.
module signed_window_scalar_recoder #(
  parameter int MAX_BITS = swsr_pkg::MAX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  swsr_pkg::in_word_t         in_data,
  output logic                       out_valid,
  output swsr_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [swsr_pkg::CFG_W-1:0] cfg_wdata
);

  logic                push;
  logic                pop;
  swsr_pkg::q_entry_t  push_entry;
  swsr_pkg::q_entry_t  head;
  swsr_pkg::q_status_t q_stat;

  swsr_front #(
    .MAX_BITS(MAX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry)
  );

  swsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_stat)
  );

  swsr_back #(
    .MAX_BITS(MAX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
